// ----- design/rmts_pkg.sv -----
// Shared types, constants and controller state encoding for the tick scheduler.
`default_nettype none

package rmts_pkg;

  // Field and register geometry
  localparam int DATA_W     = 16;
  localparam int TASK_SLOTS = 4;
  localparam int TASK_W     = 2;
  localparam int CNT_W      = 3;
  localparam int NUM_REGS   = 8;
  localparam int ADDR_W     = 5;
  localparam int PDATA_W    = 32;
  localparam int TASKS_DEF  = 4;

  // Register map: index of the first period and first wcet register
  localparam logic [2:0] REG_PERIOD0 = 3'd0;
  localparam logic [2:0] REG_WCET0   = 3'd4;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [TASK_W-1:0] task_id_t;
  typedef logic [TASK_SLOTS-1:0][DATA_W-1:0] word_bank_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VISIT,
    ST_DONE
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic     clear;   // restart: drop all scheduling state
    logic     start;   // a tick has been accepted
    logic     visit;   // release check of task idx
    task_id_t idx;
    logic     finish;  // run the top task and load the result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             stopped;
    logic             miss_now;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- design/rate_monotonic_tick_scheduler_top.sv -----
// Rate-monotonic tick scheduler: APB register bank, sequencer and datapath.
`default_nettype none

// Each accepted input is one scheduler tick and yields one result. The
// sequencer visits the tasks one after another for the release check, then
// runs the top task and loads the result register once the output is free,
// and returns to idle before it takes a new tick. A halted tick, or one that
// finds a deadline miss, ends early. The next tick is taken while a result
// still waits on a stalled output. Periods and worst-case times are written
// through the APB port; the user must write them only while no tick is in
// progress, as the block itself does not enforce it. A restart tick clears
// the schedule but keeps the registers.
module rate_monotonic_tick_scheduler_top #(
  parameter int TASKS = rmts_pkg::TASKS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire                            in_restart,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic                           out_busy_res,
  output logic [1:0]                     out_running_task,
  output logic                           out_deadline_miss,
  output logic                           out_halted,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [rmts_pkg::ADDR_W-1:0]    paddr,
  input  wire  [rmts_pkg::PDATA_W-1:0]   pwdata,
  output logic [rmts_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import rmts_pkg::*;

  word_bank_t  period_r;
  word_bank_t  wcet_r;
  dp_cmd_t     cmd;
  dp_cmd_t     cmd_q;
  dp_status_t  status;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register bank write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < TASK_SLOTS; t++) begin
        period_r[t] <= '0;
        wcet_r[t]   <= word_t'(1);
      end
    end else if (wr_en) begin
      if (reg_idx < REG_WCET0) begin
        period_r[TASK_W'(reg_idx - REG_PERIOD0)] <= pwdata[DATA_W-1:0];
      end else begin
        wcet_r[TASK_W'(reg_idx - REG_WCET0)] <= pwdata[DATA_W-1:0];
      end
    end
  end

  // Register bank read
  always_comb begin
    if (reg_idx < REG_WCET0) begin
      prdata = PDATA_W'(period_r[TASK_W'(reg_idx - REG_PERIOD0)]);
    end else begin
      prdata = PDATA_W'(wcet_r[TASK_W'(reg_idx - REG_WCET0)]);
    end
  end

  // Restart travels with the accepted transfer into the clear command
  always_comb begin
    cmd_q       = cmd;
    cmd_q.clear = cmd.start && in_restart;
  end

  rmts_ctrl #(
    .TASKS (TASKS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rmts_dp #(
    .TASKS (TASKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd_q),
    .status            (status),
    .period_i          (period_r),
    .wcet_i            (wcet_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_busy_res      (out_busy_res),
    .out_running_task  (out_running_task),
    .out_deadline_miss (out_deadline_miss),
    .out_halted        (out_halted)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.count <= CNT_W'(TASKS))
    else $error("ready stack holds more entries than tasks");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("tick taken while the previous one is still in progress");

  a_miss_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_deadline_miss) |-> (out_halted && !out_busy_res))
    else $error("deadline miss reported without halting");

  a_halt_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.visit && status.stopped) |=> !cmd.visit)
    else $error("release check continued while halted");
`endif

endmodule

`default_nettype wire

// ----- design/rmts_ctrl.sv -----
// Tick sequencer: accepts a tick, walks the tasks one per cycle, then finishes.
`default_nettype none

module rmts_ctrl #(
  parameter int TASKS = rmts_pkg::TASKS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  rmts_pkg::dp_status_t status,
  output rmts_pkg::dp_cmd_t    cmd
);
  import rmts_pkg::*;

  localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;

  ctrl_state_t       state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              accept;
  logic              idx_last;

  assign accept   = in_valid && !in_stall;
  assign idx_last = (idx_r == IDX_W'(TASKS - 1));

  // Next state and task counter
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_VISIT;
          idx_nxt   = '0;
        end
      end
      ST_VISIT: begin
        if (status.stopped || status.miss_now || idx_last) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    in_stall   = 1'b1;
    cmd        = '0;
    cmd.idx    = TASK_W'(idx_r);
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      ST_VISIT: cmd.visit  = 1'b1;
      ST_DONE:  cmd.finish = status.out_free;
      default:  cmd        = '0;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/rmts_dp.sv -----
// Scheduler datapath: per-task lanes, sorted ready stack and result register.
`default_nettype none

module rmts_dp #(
  parameter int TASKS = rmts_pkg::TASKS_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  rmts_pkg::dp_cmd_t        cmd,
  output rmts_pkg::dp_status_t     status,
  input  rmts_pkg::word_bank_t     period_i,
  input  rmts_pkg::word_bank_t     wcet_i,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic                     out_busy_res,
  output logic [1:0]               out_running_task,
  output logic                     out_deadline_miss,
  output logic                     out_halted
);
  import rmts_pkg::*;

  localparam int CW = $clog2(TASKS + 1);

  word_t            phase_r [TASKS];
  word_t            phase_nxt [TASKS];
  word_t            rem_r [TASKS];
  word_t            rem_nxt [TASKS];
  task_id_t         stack_r [TASKS];
  task_id_t         stack_nxt [TASKS];
  logic [CW-1:0]    count_r, count_nxt;
  logic             stopped_r, miss_r;
  logic             out_valid_r;
  logic             out_free;

  logic             sel_en, sel_phase_zero, sel_pending;
  logic             do_release, do_push, miss_now;
  task_id_t         top;
  word_t            rem_top;
  logic             run, do_run, do_pop;
  task_id_t         tmp_id;

  assign out_free = !out_valid_r || !out_stall;

  // Select the lane under release check
  always_comb begin
    sel_en         = 1'b0;
    sel_phase_zero = 1'b0;
    sel_pending    = 1'b0;
    for (int t = 0; t < TASKS; t++) begin
      if (cmd.idx == TASK_W'(t)) begin
        sel_en         = (period_i[t] != '0);
        sel_phase_zero = (phase_r[t] == '0);
        sel_pending    = (rem_r[t] != '0);
      end
    end
  end

  assign do_release = cmd.visit && !stopped_r && sel_en;
  assign miss_now   = do_release && sel_phase_zero && sel_pending;
  assign do_push    = do_release && sel_phase_zero && !sel_pending;

  // Top of stack and its outstanding work
  assign top = stack_r[0];
  always_comb begin
    rem_top = '0;
    for (int t = 0; t < TASKS; t++) begin
      if (top == TASK_W'(t)) begin
        rem_top = rem_r[t];
      end
    end
  end

  assign run    = !stopped_r && (count_r != '0);
  assign do_run = cmd.finish && run;
  assign do_pop = do_run && (rem_top <= word_t'(1));

  // Lane updates: clear, reload or count down the phase, load or burn work
  always_comb begin
    for (int t = 0; t < TASKS; t++) begin
      phase_nxt[t] = phase_r[t];
      rem_nxt[t]   = rem_r[t];
      if (cmd.clear) begin
        phase_nxt[t] = '0;
        rem_nxt[t]   = '0;
      end else if (do_release && !miss_now && cmd.idx == TASK_W'(t)) begin
        if (phase_r[t] == '0) begin
          rem_nxt[t]   = (wcet_i[t] == '0) ? word_t'(1) : wcet_i[t];
          phase_nxt[t] = period_i[t] - word_t'(1);
        end else begin
          phase_nxt[t] = phase_r[t] - word_t'(1);
        end
      end else if (do_run && top == TASK_W'(t) && rem_r[t] != '0) begin
        rem_nxt[t] = rem_r[t] - word_t'(1);
      end
    end
  end

  // Ready stack, top at slot 0: clear, push with one bubble pass, or pop
  always_comb begin
    tmp_id = '0;
    for (int j = 0; j < TASKS; j++) begin
      stack_nxt[j] = stack_r[j];
    end
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (do_push && count_r < CW'(TASKS)) begin
      for (int j = TASKS - 1; j > 0; j--) begin
        stack_nxt[j] = stack_r[j-1];
      end
      stack_nxt[0] = cmd.idx;
      count_nxt    = count_r + CW'(1);
      for (int j = 0; j < TASKS - 1; j++) begin
        if ((CW'(j + 1) < count_nxt) &&
            (period_i[stack_nxt[j]] > period_i[stack_nxt[j+1]])) begin
          tmp_id         = stack_nxt[j];
          stack_nxt[j]   = stack_nxt[j+1];
          stack_nxt[j+1] = tmp_id;
        end
      end
    end else if (do_pop) begin
      for (int j = 0; j < TASKS - 1; j++) begin
        stack_nxt[j] = stack_r[j+1];
      end
      count_nxt = count_r - CW'(1);
    end
  end

  // Hold lane and stack state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < TASKS; t++) begin
        phase_r[t] <= '0;
        rem_r[t]   <= '0;
      end
      count_r <= '0;
    end else begin
      for (int t = 0; t < TASKS; t++) begin
        phase_r[t] <= phase_nxt[t];
        rem_r[t]   <= rem_nxt[t];
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < TASKS; j++) begin
      stack_r[j] <= stack_nxt[j];
    end
  end

  // Halt and miss flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stopped_r <= 1'b0;
      miss_r    <= 1'b0;
    end else if (cmd.clear) begin
      stopped_r <= 1'b0;
      miss_r    <= 1'b0;
    end else if (miss_now) begin
      stopped_r <= 1'b1;
      miss_r    <= 1'b1;
    end else if (cmd.start) begin
      miss_r <= 1'b0;
    end
  end

  // Result register: load on finish, drop once the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_busy_res      <= run;
      out_running_task  <= run ? top : task_id_t'(0);
      out_deadline_miss <= miss_r;
      out_halted        <= stopped_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    status          = '0;
    status.stopped  = stopped_r;
    status.miss_now = miss_now;
    status.out_free = out_free;
    status.count    = CNT_W'(count_r);
  end

endmodule

`default_nettype wire

// ----- dv/tb_rate_monotonic_tick_scheduler_top.sv -----
// Self-checking testbench for the rate-monotonic tick scheduler top level.

// One result transfer of the scheduler
typedef struct packed {
  logic               busy;
  rmts_pkg::task_id_t task_id;
  logic               miss;
  logic               halted;
} tick_result_t;

// Predicts the schedule tick by tick and checks results in order
class sched_scoreboard;
  rmts_pkg::word_t    period [rmts_pkg::TASK_SLOTS];
  rmts_pkg::word_t    wcet [rmts_pkg::TASK_SLOTS];
  rmts_pkg::word_t    phase [rmts_pkg::TASK_SLOTS];
  rmts_pkg::word_t    work [rmts_pkg::TASK_SLOTS];
  rmts_pkg::task_id_t ready [rmts_pkg::TASK_SLOTS];
  int unsigned        depth;
  bit                 stopped;
  tick_result_t       expected_q [$];
  int unsigned        mismatches, checked;
  int unsigned        ticks, busy_ticks, misses, halted_ticks, restarts;

  function new();
    for (int i = 0; i < rmts_pkg::TASK_SLOTS; i++) begin
      period[i] = '0;
      wcet[i]   = 16'd1;
    end
    clear_sched();
  endfunction

  function void clear_sched();
    for (int i = 0; i < rmts_pkg::TASK_SLOTS; i++) begin
      phase[i] = '0;
      work[i]  = '0;
      ready[i] = '0;
    end
    depth   = 0;
    stopped = 1'b0;
  endfunction

  function void set_reg(int idx, rmts_pkg::word_t val);
    if (idx < rmts_pkg::TASK_SLOTS) period[idx] = val;
    else if (idx < rmts_pkg::NUM_REGS) wcet[idx - rmts_pkg::TASK_SLOTS] = val;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // Push a released task, then bubble it below any shorter period
  function void push_ready(int id);
    rmts_pkg::task_id_t a, b;
    if (depth >= rmts_pkg::TASK_SLOTS) return;
    ready[depth] = rmts_pkg::task_id_t'(id);
    depth++;
    for (int k = int'(depth) - 1; k > 0; k--) begin
      a = ready[k];
      b = ready[k-1];
      if (period[a] > period[b]) begin
        ready[k-1] = a;
        ready[k]   = b;
      end
    end
  endfunction

  // Work out the result of one accepted tick
  function void note_tick(logic restart);
    tick_result_t       r;
    rmts_pkg::task_id_t top;
    r = '0;
    ticks++;
    if (restart) begin
      restarts++;
      clear_sched();
    end
    if (stopped) begin
      r.halted = 1'b1;
      halted_ticks++;
      expected_q.push_back(r);
      return;
    end
    for (int i = 0; i < rmts_pkg::TASK_SLOTS; i++) begin
      if (period[i] == 0) continue;
      if (phase[i] == 0) begin
        if (work[i] != 0) begin
          stopped  = 1'b1;
          r.miss   = 1'b1;
          r.halted = 1'b1;
          misses++;
          expected_q.push_back(r);
          return;
        end
        work[i] = (wcet[i] == 0) ? 16'd1 : wcet[i];
        push_ready(i);
        phase[i] = rmts_pkg::word_t'(period[i] - 16'd1);
      end else begin
        phase[i] = rmts_pkg::word_t'(phase[i] - 16'd1);
      end
    end
    // Run the top task for one unit
    if (depth > 0) begin
      top = ready[depth-1];
      if (work[top] > 0) work[top] = rmts_pkg::word_t'(work[top] - 16'd1);
      r.busy    = 1'b1;
      r.task_id = top;
      busy_ticks++;
      if (work[top] == 0) depth--;
    end
    expected_q.push_back(r);
  endfunction

  function void check_result(tick_result_t got);
    tick_result_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] result with no tick pending: busy=%0b task=%0d miss=%0b halted=%0b",
                 $time, got.busy, got.task_id, got.miss, got.halted);
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (got.busy !== want.busy || got.task_id !== want.task_id ||
        got.miss !== want.miss || got.halted !== want.halted) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"[%0t] result %0d: expected busy=%0b task=%0d miss=%0b halted=%0b,",
                  " got busy=%0b task=%0d miss=%0b halted=%0b"},
                 $time, checked, want.busy, want.task_id, want.miss, want.halted,
                 got.busy, got.task_id, got.miss, got.halted);
    end
  endfunction
endclass

module tb_rate_monotonic_tick_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rmts_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_TICKS = 1650;
  localparam int PHASES       = 8;
  localparam int SETTLE       = TASKS_DEF + 6;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_restart;
  logic                out_valid;
  logic                out_stall;
  logic                out_busy_res;
  logic [1:0]          out_running_task;
  logic                out_deadline_miss;
  logic                out_halted;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  sched_scoreboard sb;
  int              idle_max;
  int unsigned     cycles;
  int unsigned     cfg_writes;

  rate_monotonic_tick_scheduler_top #(.TASKS(TASKS_DEF)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_busy_res     (out_busy_res),
    .out_running_task (out_running_task),
    .out_deadline_miss(out_deadline_miss),
    .out_halted       (out_halted),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort the run if it overstays its cycle budget
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles", cycles);
    $display("Verification failed");
    $finish;
  end

  // Write one register through the APB port: setup, then access
  task automatic apb_write(input int idx, input word_t val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= {16'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
    cfg_writes++;
  endtask

  task automatic set_task(input int id, input word_t per, input word_t cost);
    apb_write(int'(REG_PERIOD0) + id, per);
    apb_write(int'(REG_WCET0) + id, cost);
  endtask

  // Offer one tick after a random gap and hold it until the transfer
  task automatic send_tick(input logic restart);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(restart);
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Accept results with a random stall before each transfer
  task automatic take_results();
    int           hold;
    tick_result_t got;
    forever begin
      hold = $urandom_range(0, idle_max);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = {out_busy_res, out_running_task, out_deadline_miss, out_halted};
      sb.check_result(got);
    end
  endtask

  // Pick a schedule of the given flavour for all four tasks
  task automatic load_random_config(input int kind);
    word_t per, cost;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      case (kind)
        0: begin
          // loose schedule: utilisation stays under the bound
          per  = ($urandom_range(0, 3) == 0) ? 16'd0 : word_t'($urandom_range(6, 30));
          cost = word_t'($urandom_range(0, per / 6));
        end
        1: begin
          // tight schedule: misses come often
          per  = word_t'($urandom_range(0, 8));
          cost = word_t'($urandom_range(0, 4));
        end
        2: begin
          // extremes of both registers
          case ($urandom_range(0, 3))
            0: per = 16'd0;
            1: per = 16'd1;
            2: per = 16'hFFFF;
            default: per = word_t'($urandom());
          endcase
          case ($urandom_range(0, 3))
            0: cost = 16'd0;
            1: cost = 16'd1;
            2: cost = 16'hFFFF;
            default: cost = word_t'($urandom_range(0, 40));
          endcase
        end
        default: begin
          // harmonic periods
          per  = word_t'(1 << $urandom_range(1, 5));
          cost = word_t'($urandom_range(0, per / 4));
        end
      endcase
      set_task(i, per, cost);
    end
  endtask

  initial begin
    int per_phase;
    logic restart;

    sb         = new();
    cfg_writes = 0;
    idle_max   = 6;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_restart <= 1'b0;
    out_stall  <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      take_results();
    join_none

    // Reset registers: every task disabled, ticks stay idle
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();

    // Period-one task with zero wcet starves task 1 into a miss, then halt
    set_task(0, 16'd1, 16'd0);
    set_task(1, 16'd3, 16'd1);
    set_task(2, 16'd0, 16'd5);
    set_task(3, 16'hFFFF, 16'hFFFF);
    send_tick(1'b1);
    repeat (6) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();

    // Largest periods and worst-case times
    for (int i = 0; i < TASK_SLOTS; i++) set_task(i, 16'hFFFF, 16'hFFFF);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    drain();

    // Descending periods: the last task released must land on top
    for (int i = 0; i < TASK_SLOTS; i++) set_task(i, word_t'(9 - 2 * i), 16'd1);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    drain();

    // Random phases, each under its own schedule
    per_phase = RANDOM_TICKS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      idle_max = (ph % 3 == 2) ? 0 : 6;
      load_random_config(ph % 4);
      for (int n = 0; n < per_phase; n++) begin
        // restart mostly to leave a halt, seldom otherwise
        if (n == 0) restart = 1'b1;
        else if (sb.stopped) restart = ($urandom_range(0, 2) == 0);
        else restart = ($urandom_range(0, 39) == 0);
        send_tick(restart);
        if (ph == 1 && n == per_phase / 2) drain();
      end
      drain();
    end

    $display("Ran %0d ticks under %0d register writes: %0d busy, %0d misses, %0d halted, %0d restarts",
             sb.ticks, cfg_writes, sb.busy_ticks, sb.misses, sb.halted_ticks, sb.restarts);
    $display("Checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
